// File: rtl/core/cjc_pkg.sv
`default_nettype none

package cjc_pkg;

	localparam int unsigned CRIT_W  = 5;
	localparam int unsigned MINOR_W = 23;
	localparam int unsigned CONN_W  = 2;
	localparam int unsigned STATE_W = 4;
	localparam int unsigned TOTAL_W = 5;

	// Bit of critical_faults that reports the assist supply as down.
	localparam int unsigned CRIT_ASSIST_DOWN_BIT = 1;

	typedef enum logic [STATE_W-1:0] {
		JS_IDLE      = 4'd0,
		JS_SETTING   = 4'd1,
		JS_WAITING   = 4'd2,
		JS_STANDBY   = 4'd3,
		JS_WORKING   = 4'd4,
		JS_ERR_PAUSE = 4'd5,
		JS_MAN_PAUSE = 4'd6,
		JS_RESUMING  = 4'd7,
		JS_ABORTING  = 4'd8,
		JS_DONE      = 4'd9,
		JS_EXITING   = 4'd10,
		JS_DETACHING = 4'd11
	} job_state_t;

	typedef enum logic [CONN_W-1:0] {
		CONN_UNDEF   = 2'd0,
		CONN_INVALID = 2'd1,
		CONN_GUN_ONE = 2'd2,
		CONN_GUN_TWO = 2'd3
	} conn_t;

	typedef enum logic {
		MODE_TICK = 1'b0,
		MODE_LOAD = 1'b1
	} mode_t;

	// One request as held in the input register.
	typedef struct packed {
		mode_t              mode;
		logic [STATE_W-1:0] new_state;
		logic [CRIT_W-1:0]  critical_faults;
		logic [MINOR_W-1:0] minor_faults;
		conn_t              gun_connection;
		logic               gun1_assist_status;
		logic               gun2_assist_status;
		logic               bms_recognized;
		logic               card_triggered;
		logic               card_confirmed;
		logic               abort_request;
		logic               manual_pause;
	} req_t;

	// Job state and command registers as seen after a request.
	typedef struct packed {
		job_state_t         job_state;
		logic [STATE_W-1:0] paused_from;
		logic               abort_pending;
		logic               dc_output;
		logic               gun1_output;
		logic               gun2_output;
		logic               gun1_assist;
		logic               gun2_assist;
	} job_t;

	// Fault summary for one request.
	typedef struct packed {
		logic               charge_allow;
		logic               error_flag;
		logic [TOTAL_W-1:0] fault_total;
	} fault_sum_t;

endpackage

`default_nettype wire

// File: rtl/core/charge_job_controller_core.sv
`default_nettype none

// Charge job controller core. Every request is either a periodic tick
// (mode 0) or a load of the job state (mode 1, new_state codes 12 to 15
// are ignored). For each request exactly one result comes out: the fault
// summary of that request (charge_allow, error_flag, fault_total) and the
// job state, paused-from state and output commands as they stand after it.
// A request passes an input register, then one pass of fault counting and
// job-machine logic, and lands in the result register, which drives out_valid;
// one request is taken every cycle while results are drained.
// The result register and the input register are separate stages, so a
// waiting result does not block the next request from being taken.
// Assist commands are only ever set; only reset clears them. An abort
// request is latched and kept until working, error pause or manual pause
// acts on it.
module charge_job_controller_core
	import cjc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               mode,
	input  wire logic [STATE_W-1:0] new_state,
	input  wire logic [CRIT_W-1:0]  critical_faults,
	input  wire logic [MINOR_W-1:0] minor_faults,
	input  wire logic [CONN_W-1:0]  gun_connection,
	input  wire logic               gun1_assist_status,
	input  wire logic               gun2_assist_status,
	input  wire logic               bms_recognized,
	input  wire logic               card_triggered,
	input  wire logic               card_confirmed,
	input  wire logic               abort_request,
	input  wire logic               manual_pause,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [STATE_W-1:0]      job_state,
	output logic                    charge_allow,
	output logic                    error_flag,
	output logic [TOTAL_W-1:0]      fault_total,
	output logic                    dc_output_on,
	output logic                    gun1_output_on,
	output logic                    gun2_output_on,
	output logic                    gun1_assist_on,
	output logic                    gun2_assist_on,
	output logic [STATE_W-1:0]      paused_from_state
);

	logic       valid_s1;
	req_t       req_s1;
	logic       valid_s2;
	fault_sum_t sum_s2;
	job_t       job_s2;

	fault_sum_t sum;
	job_t       job_next;
	logic       advance;

	// Move the held request on when the result register is free or draining.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Capture the request; payload needs no reset.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= '{
				mode:               mode_t'(mode),
				new_state:          new_state,
				critical_faults:    critical_faults,
				minor_faults:       minor_faults,
				gun_connection:     conn_t'(gun_connection),
				gun1_assist_status: gun1_assist_status,
				gun2_assist_status: gun2_assist_status,
				bms_recognized:     bms_recognized,
				card_triggered:     card_triggered,
				card_confirmed:     card_confirmed,
				abort_request:      abort_request,
				manual_pause:       manual_pause
			};
		end
	end

	cjc_fault_count u_fault_count (
		.critical_faults (req_s1.critical_faults),
		.minor_faults    (req_s1.minor_faults),
		.sum             (sum)
	);

	// Job state and commands advance only when the request leaves stage one,
	// so every request updates them exactly once and in order.
	cjc_job_fsm u_job_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.req      (req_s1),
		.allow    (sum.charge_allow),
		.job_next (job_next)
	);

	// Hold the result until it is taken.
	always_ff @(posedge clk) begin
		if (advance) begin
			sum_s2 <= sum;
			job_s2 <= job_next;
		end
	end

	assign out_valid         = valid_s2;
	assign job_state         = STATE_W'(job_s2.job_state);
	assign charge_allow      = sum_s2.charge_allow;
	assign error_flag        = sum_s2.error_flag;
	assign fault_total       = sum_s2.fault_total;
	assign dc_output_on      = job_s2.dc_output;
	assign gun1_output_on    = job_s2.gun1_output;
	assign gun2_output_on    = job_s2.gun2_output;
	assign gun1_assist_on    = job_s2.gun1_assist;
	assign gun2_assist_on    = job_s2.gun2_assist;
	assign paused_from_state = job_s2.paused_from;

endmodule

`default_nettype wire

// File: rtl/core/cjc_fault_count.sv
`default_nettype none

module cjc_fault_count
	import cjc_pkg::*;
(
	input  wire logic [CRIT_W-1:0]  critical_faults,
	input  wire logic [MINOR_W-1:0] minor_faults,
	output fault_sum_t              sum
);

	localparam int unsigned N_BITS = CRIT_W + MINOR_W;
	localparam int unsigned N_NIB  = (N_BITS + 3) / 4;

	logic [4*N_NIB-1:0] bits;
	logic [2:0]         nib [N_NIB];
	logic [TOTAL_W-1:0] total;

	assign bits = (4*N_NIB)'({critical_faults, minor_faults});

	// Count set bits a nibble at a time, then add the nibble counts.
	always_comb begin
		for (int g = 0; g < N_NIB; g++) begin
			nib[g] = (3'(bits[4*g]) + 3'(bits[4*g+1])) +
					(3'(bits[4*g+2]) + 3'(bits[4*g+3]));
		end
		total = '0;
		for (int g = 0; g < N_NIB; g++) begin
			total = total + TOTAL_W'(nib[g]);
		end
	end

	assign sum.fault_total  = total;
	assign sum.charge_allow = (critical_faults == '0);
	assign sum.error_flag   = (total != '0);

endmodule

`default_nettype wire

// File: rtl/core/cjc_job_fsm.sv
`default_nettype none

module cjc_job_fsm
	import cjc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic advance,
	input  wire req_t req,
	input  wire logic allow,
	output job_t      job_next
);

	job_t job_q;
	job_t nxt;
	logic assist_ok;
	logic gun_seen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_q <= '{job_state: JS_IDLE, paused_from: '0, default: 1'b0};
		end else if (advance) begin
			job_q <= nxt;
		end
	end

	assign assist_ok = !req.critical_faults[CRIT_ASSIST_DOWN_BIT];
	assign gun_seen  = (req.gun_connection == CONN_GUN_ONE) ||
			(req.gun_connection == CONN_GUN_TWO);

	always_comb begin
		nxt = job_q;
		if (req.mode == MODE_LOAD) begin
			// Ignore codes past the last state.
			if (req.new_state <= STATE_W'(JS_DETACHING)) begin
				nxt.job_state = job_state_t'(req.new_state);
			end
		end else begin
			nxt.abort_pending = job_q.abort_pending | req.abort_request;
			unique case (job_q.job_state)
				JS_IDLE, JS_SETTING, JS_WAITING: begin
					nxt.dc_output   = 1'b0;
					nxt.gun1_output = 1'b0;
					nxt.gun2_output = 1'b0;
				end
				JS_STANDBY: begin
					nxt.dc_output   = 1'b0;
					nxt.gun1_output = 1'b0;
					nxt.gun2_output = 1'b0;
					if (req.gun_connection == CONN_GUN_ONE) begin
						if (!req.gun1_assist_status && assist_ok) begin
							nxt.gun1_assist = 1'b1;
						end
					end else if (req.gun_connection == CONN_GUN_TWO) begin
						if (!req.gun2_assist_status && assist_ok) begin
							nxt.gun2_assist = 1'b1;
						end
					end
					if (gun_seen && req.bms_recognized) begin
						if (!allow) begin
							nxt.job_state = JS_ERR_PAUSE;
						end else if (req.card_triggered && req.card_confirmed) begin
							nxt.job_state = JS_WORKING;
						end
					end
				end
				JS_WORKING: begin
					if (!allow) begin
						nxt.dc_output   = 1'b0;
						nxt.gun1_output = 1'b0;
						nxt.gun2_output = 1'b0;
						nxt.paused_from = STATE_W'(JS_WORKING);
						nxt.job_state   = JS_ERR_PAUSE;
					end else begin
						nxt.dc_output = 1'b1;
						if (req.gun_connection == CONN_GUN_ONE) begin
							nxt.gun1_output = 1'b1;
							nxt.gun2_output = 1'b0;
						end else if (req.gun_connection == CONN_GUN_TWO) begin
							nxt.gun1_output = 1'b0;
							nxt.gun2_output = 1'b1;
						end
						if (nxt.abort_pending) begin
							nxt.abort_pending = 1'b0;
							nxt.paused_from   = STATE_W'(JS_WORKING);
							nxt.job_state     = JS_ABORTING;
						end else if (req.manual_pause) begin
							nxt.paused_from = STATE_W'(JS_WORKING);
							nxt.job_state   = JS_MAN_PAUSE;
						end
					end
				end
				JS_ERR_PAUSE, JS_MAN_PAUSE: begin
					nxt.gun1_output = 1'b0;
					nxt.gun2_output = 1'b0;
					if (!allow) begin
						if (nxt.abort_pending) begin
							nxt.abort_pending = 1'b0;
							nxt.job_state     = JS_ABORTING;
						end
					end else if (job_q.job_state == JS_ERR_PAUSE || !req.manual_pause) begin
						nxt.job_state = JS_RESUMING;
					end
				end
				JS_ABORTING, JS_EXITING: begin
					nxt.gun1_output = 1'b0;
					nxt.gun2_output = 1'b0;
				end
				JS_DETACHING: begin
					nxt.dc_output   = 1'b0;
					nxt.gun1_output = 1'b0;
					nxt.gun2_output = 1'b0;
					nxt.job_state   = JS_IDLE;
				end
				default: begin
					// Resuming and done hold state and commands.
				end
			endcase
		end
	end

	assign job_next = nxt;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none

module tb_top;
	import cjc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// One queued request, with a mark that holds it back until the block has drained
	typedef struct {
		req_t req;
		bit   drain;
	} queued_req_t;

	// What the block must show for one request
	typedef struct packed {
		logic [STATE_W-1:0] job_state;
		fault_sum_t         faults;
		logic               dc_output;
		logic               gun1_output;
		logic               gun2_output;
		logic               gun1_assist;
		logic               gun2_assist;
		logic [STATE_W-1:0] paused_from;
	} job_status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_ready = 1'b0;
	req_t drv_req = '0;

	logic               in_ready;
	logic               out_valid;
	logic [STATE_W-1:0] job_state;
	logic               charge_allow;
	logic               error_flag;
	logic [TOTAL_W-1:0] fault_total;
	logic               dc_output_on;
	logic               gun1_output_on;
	logic               gun2_output_on;
	logic               gun1_assist_on;
	logic               gun2_assist_on;
	logic [STATE_W-1:0] paused_from_state;

	queued_req_t request_q[$];
	job_status_t expected_status_q[$];
	job_t        job_mdl = '0;

	logic in_fire_q = 1'b0;
	int   burst_left = 8;
	int   gap_left = 0;
	int   results_seen = 0;
	int   n_err = 0;

	// receiver stall pattern state
	int   rx_mode = 0;
	int   rx_left = 0;
	int   rx_cyc = 0;
	int   hold_left = 0;
	bit   long_hold_done = 1'b0;

	charge_job_controller_core u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.mode               (drv_req.mode),
		.new_state          (drv_req.new_state),
		.critical_faults    (drv_req.critical_faults),
		.minor_faults       (drv_req.minor_faults),
		.gun_connection     (drv_req.gun_connection),
		.gun1_assist_status (drv_req.gun1_assist_status),
		.gun2_assist_status (drv_req.gun2_assist_status),
		.bms_recognized     (drv_req.bms_recognized),
		.card_triggered     (drv_req.card_triggered),
		.card_confirmed     (drv_req.card_confirmed),
		.abort_request      (drv_req.abort_request),
		.manual_pause       (drv_req.manual_pause),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.job_state          (job_state),
		.charge_allow       (charge_allow),
		.error_flag         (error_flag),
		.fault_total        (fault_total),
		.dc_output_on       (dc_output_on),
		.gun1_output_on     (gun1_output_on),
		.gun2_output_on     (gun2_output_on),
		.gun1_assist_on     (gun1_assist_on),
		.gun2_assist_on     (gun2_assist_on),
		.paused_from_state  (paused_from_state)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Hold reset at start; release it on a falling edge, off the rising edge
	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
	end

	// Advance the mirrored job machine by one request and return what the block must show.
	// The fault summary always comes from the request itself, load or tick.
	function automatic job_status_t step_job_machine(input req_t r);
		job_status_t st;
		logic        allow;
		st.faults.fault_total  = TOTAL_W'($countones(r.critical_faults) +
				$countones(r.minor_faults));
		st.faults.error_flag   = (st.faults.fault_total != 0);
		st.faults.charge_allow = (r.critical_faults == '0);
		allow = st.faults.charge_allow;

		if (r.mode == MODE_LOAD) begin
			// codes above detaching are dropped, state kept
			if (r.new_state <= JS_DETACHING)
				job_mdl.job_state = job_state_t'(r.new_state);
		end else begin
			if (r.abort_request)
				job_mdl.abort_pending = 1'b1;
			case (job_mdl.job_state)
				JS_IDLE, JS_SETTING, JS_WAITING: begin
					job_mdl.dc_output   = 1'b0;
					job_mdl.gun1_output = 1'b0;
					job_mdl.gun2_output = 1'b0;
				end
				JS_STANDBY: begin
					job_mdl.dc_output   = 1'b0;
					job_mdl.gun1_output = 1'b0;
					job_mdl.gun2_output = 1'b0;
					if (r.gun_connection == CONN_GUN_ONE || r.gun_connection == CONN_GUN_TWO) begin
						// assist is only ever switched on, and never with its supply down
						if (!r.critical_faults[CRIT_ASSIST_DOWN_BIT]) begin
							if (r.gun_connection == CONN_GUN_ONE && !r.gun1_assist_status)
								job_mdl.gun1_assist = 1'b1;
							if (r.gun_connection == CONN_GUN_TWO && !r.gun2_assist_status)
								job_mdl.gun2_assist = 1'b1;
						end
						if (r.bms_recognized) begin
							// paused_from is left alone on this path
							if (!allow)
								job_mdl.job_state = JS_ERR_PAUSE;
							else if (r.card_triggered && r.card_confirmed)
								job_mdl.job_state = JS_WORKING;
						end
					end
				end
				JS_WORKING: begin
					if (!allow) begin
						job_mdl.dc_output   = 1'b0;
						job_mdl.gun1_output = 1'b0;
						job_mdl.gun2_output = 1'b0;
						job_mdl.paused_from = JS_WORKING;
						job_mdl.job_state   = JS_ERR_PAUSE;
					end else begin
						job_mdl.dc_output = 1'b1;
						// undefined or invalid connection leaves the guns as they are
						if (r.gun_connection == CONN_GUN_ONE) begin
							job_mdl.gun2_output = 1'b0;
							job_mdl.gun1_output = 1'b1;
						end else if (r.gun_connection == CONN_GUN_TWO) begin
							job_mdl.gun1_output = 1'b0;
							job_mdl.gun2_output = 1'b1;
						end
						if (job_mdl.abort_pending) begin
							job_mdl.abort_pending = 1'b0;
							job_mdl.paused_from   = JS_WORKING;
							job_mdl.job_state     = JS_ABORTING;
						end else if (r.manual_pause) begin
							job_mdl.paused_from = JS_WORKING;
							job_mdl.job_state   = JS_MAN_PAUSE;
						end
					end
				end
				JS_ERR_PAUSE, JS_MAN_PAUSE: begin
					job_mdl.gun1_output = 1'b0;
					job_mdl.gun2_output = 1'b0;
					if (!allow) begin
						if (job_mdl.abort_pending) begin
							job_mdl.abort_pending = 1'b0;
							job_mdl.job_state     = JS_ABORTING;
						end
					end else if (job_mdl.job_state == JS_ERR_PAUSE || !r.manual_pause) begin
						job_mdl.job_state = JS_RESUMING;
					end
				end
				JS_ABORTING, JS_EXITING: begin
					job_mdl.gun1_output = 1'b0;
					job_mdl.gun2_output = 1'b0;
				end
				JS_DETACHING: begin
					job_mdl.dc_output   = 1'b0;
					job_mdl.gun1_output = 1'b0;
					job_mdl.gun2_output = 1'b0;
					job_mdl.job_state   = JS_IDLE;
				end
				default: begin
				end
			endcase
		end

		st.job_state   = job_mdl.job_state;
		st.dc_output   = job_mdl.dc_output;
		st.gun1_output = job_mdl.gun1_output;
		st.gun2_output = job_mdl.gun2_output;
		st.gun1_assist = job_mdl.gun1_assist;
		st.gun2_assist = job_mdl.gun2_assist;
		st.paused_from = job_mdl.paused_from;
		return st;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			n_err++;
		end
	endfunction

	// Every bit random: noise, and the base for load requests
	function automatic req_t random_req();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(req_t)-1:0];
	endfunction

	function automatic req_t load_req(input logic [STATE_W-1:0] target);
		req_t r;
		r = random_req();
		r.mode = MODE_LOAD;
		r.new_state = target;
		return r;
	endfunction

	function automatic req_t tick_of(input logic [CRIT_W-1:0] crit, input conn_t conn,
			input logic bms, input logic card, input logic abrt, input logic pause);
		req_t r;
		r = '0;
		r.mode            = MODE_TICK;
		r.critical_faults = crit;
		r.gun_connection  = conn;
		r.bms_recognized  = bms;
		r.card_triggered  = card;
		r.card_confirmed  = card;
		r.abort_request   = abrt;
		r.manual_pause    = pause;
		return r;
	endfunction

	// Tick biased towards a charge that progresses: faults mostly clear, a gun mostly present
	function automatic req_t random_tick();
		req_t r;
		r = random_req();
		r.mode = MODE_TICK;
		if ($urandom_range(0, 9) < 7)
			r.critical_faults = '0;
		else
			r.critical_faults = CRIT_W'($urandom_range(1, 31));
		case ($urandom_range(0, 3))
			0: r.minor_faults = '0;
			1: r.minor_faults = MINOR_W'(1) << $urandom_range(0, MINOR_W - 1);
			default: r.minor_faults = MINOR_W'($urandom);
		endcase
		if ($urandom_range(0, 9) < 8)
			r.gun_connection = conn_t'($urandom_range(CONN_GUN_ONE, CONN_GUN_TWO));
		else
			r.gun_connection = conn_t'($urandom_range(CONN_UNDEF, CONN_INVALID));
		r.bms_recognized = ($urandom_range(0, 9) < 8);
		r.card_triggered = ($urandom_range(0, 9) < 7);
		r.card_confirmed = ($urandom_range(0, 9) < 7);
		r.abort_request  = ($urandom_range(0, 19) == 0);
		r.manual_pause   = ($urandom_range(0, 3) == 0);
		return r;
	endfunction

	function automatic logic [STATE_W-1:0] pick_load_state();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 50) return JS_STANDBY;
		if (roll < 65) return JS_WORKING;
		if (roll < 75) return JS_ERR_PAUSE;
		if (roll < 85) return JS_MAN_PAUSE;
		return STATE_W'($urandom_range(0, 15));
	endfunction

	function automatic void queue_req(input req_t r);
		queued_req_t q;
		q.req   = r;
		q.drain = 1'b0;
		request_q.push_back(q);
	endfunction

	// Driver: offer the head of the request queue in bursts, with random gaps between them.
	// A request stays on the pins until the edge that takes it.
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_fire_q)) begin
			if (in_valid)
				void'(request_q.pop_front());
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (request_q.size() == 0 ||
					(request_q[0].drain && expected_status_q.size() != 0)) begin
				// hold the marked request until every result is out
				in_valid <= 1'b0;
			end else begin
				drv_req  <= request_q[0].req;
				in_valid <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					if ($urandom_range(0, 3) == 0)
						gap_left = 0;
					else if ($urandom_range(0, 3) == 0)
						gap_left = $urandom_range(5, 20);
					else
						gap_left = $urandom_range(1, 4);
				end
			end
		end
	end

	// Receiver: switch between stall patterns every so often; once, hold off for a long
	// stretch so the block backs up and stalls its input.
	always @(negedge clk) begin
		logic rdy;
		rdy = 1'b0;
		if (arst_n) begin
			rx_cyc++;
			if (!long_hold_done && results_seen >= 400) begin
				long_hold_done = 1'b1;
				hold_left = 150;
			end
			if (hold_left != 0) begin
				hold_left--;
			end else begin
				if (rx_left == 0) begin
					rx_mode = $urandom_range(0, 3);
					rx_left = $urandom_range(20, 200);
				end else begin
					rx_left--;
				end
				case (rx_mode)
					0: rdy = 1'b1;
					1: rdy = $urandom_range(0, 1);
					2: rdy = ($urandom_range(0, 3) == 0);
					default: rdy = rx_cyc[2];
				endcase
			end
		end
		out_ready <= rdy;
	end

	// Monitor: check each result against the oldest expectation, then predict for any
	// request taken at this edge, whose result comes later from the result register.
	always @(posedge clk) begin
		job_status_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_status_q.size() == 0) begin
					$error("result with no request outstanding");
					n_err++;
				end else begin
					e = expected_status_q.pop_front();
					check_field("job_state", e.job_state, job_state);
					check_field("charge_allow", e.faults.charge_allow, charge_allow);
					check_field("error_flag", e.faults.error_flag, error_flag);
					check_field("fault_total", e.faults.fault_total, fault_total);
					check_field("dc_output_on", e.dc_output, dc_output_on);
					check_field("gun1_output_on", e.gun1_output, gun1_output_on);
					check_field("gun2_output_on", e.gun2_output, gun2_output_on);
					check_field("gun1_assist_on", e.gun1_assist, gun1_assist_on);
					check_field("gun2_assist_on", e.gun2_assist, gun2_assist_on);
					check_field("paused_from_state", e.paused_from, paused_from_state);
				end
			end
			if (in_valid && in_ready)
				expected_status_q.push_back(step_job_machine(drv_req));
		end
		in_fire_q <= arst_n && in_valid && in_ready;
	end

	initial begin
		req_t r;
		int   n_rand;

		// Directed opening: field extremes, out-of-range loads, then a walk through the
		// job machine's standby, working, pause and detaching states and every way out of them.
		queue_req(tick_of('0, CONN_UNDEF, 1'b0, 1'b0, 1'b0, 1'b0));
		r = '1;
		r.mode = MODE_TICK;
		r.abort_request = 1'b0;
		queue_req(r);
		r = '1;
		queue_req(r);                                   // load of code 15 with every fault set
		queue_req(load_req(4'd12));
		queue_req(load_req(JS_STANDBY));
		queue_req(tick_of('0, CONN_UNDEF, 1'b1, 1'b1, 1'b0, 1'b0));
		// assist supply down: no assist, critical fault with BMS up goes to error pause
		queue_req(tick_of(CRIT_W'(1) << CRIT_ASSIST_DOWN_BIT, CONN_GUN_ONE, 1'b1, 1'b0,
			1'b0, 1'b0));
		queue_req(tick_of('0, CONN_UNDEF, 1'b0, 1'b0, 1'b0, 1'b0));
		queue_req(load_req(JS_STANDBY));
		queue_req(tick_of('0, CONN_GUN_ONE, 1'b1, 1'b1, 1'b0, 1'b0));
		queue_req(tick_of('0, CONN_INVALID, 1'b0, 1'b0, 1'b0, 1'b0));
		queue_req(tick_of('0, CONN_GUN_TWO, 1'b0, 1'b0, 1'b0, 1'b1));
		queue_req(tick_of('0, CONN_GUN_TWO, 1'b0, 1'b0, 1'b0, 1'b1));
		queue_req(tick_of(5'd1, CONN_UNDEF, 1'b0, 1'b0, 1'b1, 1'b0));
		queue_req(load_req(JS_STANDBY));
		queue_req(tick_of('0, CONN_GUN_TWO, 1'b0, 1'b0, 1'b0, 1'b0));
		queue_req(load_req(JS_WORKING));
		queue_req(tick_of('0, CONN_GUN_ONE, 1'b0, 1'b0, 1'b1, 1'b0));
		queue_req(load_req(JS_WORKING));
		queue_req(tick_of(5'd16, CONN_GUN_ONE, 1'b0, 1'b0, 1'b0, 1'b0));
		queue_req(tick_of(5'd8, CONN_UNDEF, 1'b0, 1'b0, 1'b1, 1'b0));
		queue_req(load_req(JS_MAN_PAUSE));
		queue_req(tick_of('0, CONN_UNDEF, 1'b0, 1'b0, 1'b0, 1'b0));
		queue_req(load_req(JS_DETACHING));
		queue_req(tick_of('0, CONN_UNDEF, 1'b0, 1'b0, 1'b0, 1'b0));

		// Random part: mostly a load followed by a run of biased ticks, some pure noise
		n_rand = 0;
		while (n_rand < 1750) begin
			if ($urandom_range(0, 99) < 85) begin
				queue_req(load_req(pick_load_state()));
				n_rand++;
				repeat ($urandom_range(2, 14)) begin
					queue_req(random_tick());
					n_rand++;
				end
			end else begin
				repeat ($urandom_range(1, 6)) begin
					queue_req(random_req());
					n_rand++;
				end
			end
		end
		// pause the sender once mid-run until the block has drained
		request_q[900].drain = 1'b1;

		wait (request_q.size() == 0 && !in_valid && expected_status_q.size() == 0);
		repeat (8) @(posedge clk);
		if (expected_status_q.size() != 0) begin
			$error("%0d results never arrived", expected_status_q.size());
			n_err++;
		end
		if (n_err == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#1000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
